// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the positional insert list rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PIL_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pil assertion failed");

// next-cycle implication, disabled during reset
`define PIL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pil assertion failed");

`endif

// ----- rtl/pil_pkg.sv -----
// ----------------------------------------------------------------------------
// pil_pkg
// shared constants and types for the positional insert list
// ----------------------------------------------------------------------------
`default_nettype none

package pil_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STAT_W   = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ_FWD = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_BWD = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

   // what every cell does this cycle
   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_INSERT,
      MODE_ROT_FWD,
      MODE_ROT_BWD
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic [POS_W-1:0]          pos;
      logic [CNT_W-1:0]          count;
      logic signed [DATA_W-1:0]  ins_value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/pil_if.sv -----
// ----------------------------------------------------------------------------
// pil_if
// valid/ready channels for request and response transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface pil_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [pil_pkg::OP_W-1:0]             op;
   logic [pil_pkg::POS_W-1:0]            position;
   logic signed [pil_pkg::DATA_W-1:0]    value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface pil_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pil_pkg::DATA_W-1:0]    item_value;
   logic                                 last;
   logic [pil_pkg::STAT_W-1:0]           status;
   logic [pil_pkg::CNT_W-1:0]            entry_count;

   modport source (output valid, output item_value, output last, output status,
                   output entry_count, input ready);
   modport sink   (input valid, input item_value, input last, input status,
                   input entry_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/positional_insert_list.sv -----
// ----------------------------------------------------------------------------
// positional_insert_list
// ordered list of signed values with positional insert and full-list reads
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one transaction per command: op, position and value.
//   rsp_chan returns results through a one-entry output register.
//   an insert answers with one result (last set) carrying status and count;
//   the shift of later entries happens in all cells at once, so the next
//   request can be taken right behind an insert if the output can refill.
//   a read of n stored values gives n results, one per cycle while the
//   receiver takes them, front to back or back to front; the cell row rotates
//   by one per result and is back in its original order after the last
//   result. a read of an empty list gives one result with the empty status.
//   a read occupies the block until its last result; no request is taken during it.
//   op 3 is dropped without a result.
//   when the receiver stalls, the pending result holds and the read sequence
//   waits; no request is taken until the output register can be refilled.
//   reset (synchronous, active high) empties the list; the cell contents are
//   left as they are and are never read below a fresh count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module positional_insert_list (
   input  wire logic   clock,
   input  wire logic   reset,
   pil_req_if.sink     req_chan,
   pil_rsp_if.source   rsp_chan
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   // sequencer state
   state_type                           state_ff,    state_in;
   logic [pil_pkg::CNT_W-1:0]           count_ff,    count_in;
   logic [pil_pkg::CNT_W-1:0]           step_ff,     step_in;
   logic                                read_bwd_ff, read_bwd_in;

   // output register
   logic                                rsp_valid_ff,  rsp_valid_in;
   logic signed [pil_pkg::DATA_W-1:0]   rsp_value_ff,  rsp_value_in;
   logic                                rsp_last_ff,   rsp_last_in;
   logic [pil_pkg::STAT_W-1:0]          rsp_status_ff, rsp_status_in;
   logic [pil_pkg::CNT_W-1:0]           rsp_count_ff,  rsp_count_in;

   pil_pkg::cell_ctrl_type              cell_ctrl;
   logic signed [pil_pkg::DATA_W-1:0]   chain_head;
   logic signed [pil_pkg::DATA_W-1:0]   chain_tail;
   logic                                slot_free;
   logic                                req_take;
   logic                                read_done;
   logic                                pos_bad;
   logic                                list_full;

   // output register can take a new result this cycle
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && slot_free;
   assign req_take  = req_chan.valid && req_chan.ready;

   assign pos_bad   = req_chan.position > pil_pkg::POS_W'(count_ff);
   assign list_full = count_ff >= pil_pkg::CNT_W'(pil_pkg::CAPACITY);
   assign read_done = (step_ff + pil_pkg::CNT_W'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      read_bwd_in   = read_bwd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      cell_ctrl.mode      = pil_pkg::MODE_HOLD;
      cell_ctrl.pos       = req_chan.position;
      cell_ctrl.count     = count_ff;
      cell_ctrl.ins_value = req_chan.value;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_chan.op)
                  pil_pkg::OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_last_in  = 1'b1;
                     rsp_count_in = count_ff;
                     if (pos_bad) begin
                        // range check wins over full check
                        rsp_status_in = pil_pkg::ST_RANGE;
                     end else if (list_full) begin
                        rsp_status_in = pil_pkg::ST_FULL;
                     end else begin
                        rsp_status_in  = pil_pkg::ST_OK;
                        cell_ctrl.mode = pil_pkg::MODE_INSERT;
                        count_in       = count_ff + pil_pkg::CNT_W'(1);
                        rsp_count_in   = count_ff + pil_pkg::CNT_W'(1);
                     end
                  end
                  pil_pkg::OP_READ_FWD, pil_pkg::OP_READ_BWD: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = pil_pkg::ST_EMPTY;
                        rsp_count_in  = count_ff;
                     end else begin
                        state_in    = S_READ;
                        step_in     = '0;
                        read_bwd_in = (req_chan.op == pil_pkg::OP_READ_BWD);
                     end
                  end
                  default: begin
                     // unused op: no result, no change
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            if (slot_free) begin
               // emit the current end, then rotate the row by one
               rsp_valid_in   = 1'b1;
               rsp_value_in   = read_bwd_ff ? chain_tail : chain_head;
               rsp_last_in    = read_done;
               rsp_status_in  = pil_pkg::ST_OK;
               rsp_count_in   = count_ff;
               cell_ctrl.mode = read_bwd_ff ? pil_pkg::MODE_ROT_BWD : pil_pkg::MODE_ROT_FWD;
               step_in        = step_ff + pil_pkg::CNT_W'(1);
               if (read_done) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         read_bwd_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         read_bwd_ff  <= read_bwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // list storage: one cell per entry
   pil_chain u_chain (
      .clock (clock),
      .ctrl  (cell_ctrl),
      .head  (chain_head),
      .tail  (chain_tail)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.item_value  = rsp_value_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   // count never passes capacity
   `PIL_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
      count_ff <= pil_pkg::CNT_W'(pil_pkg::CAPACITY))

   // no new request while a read sequence is running
   `PIL_ASSERT_IMPL(a_busy_no_take, clock, reset, state_ff == S_READ, !req_chan.ready)

   // a good insert grows the list by exactly one
   `PIL_ASSERT_NEXT(a_insert_grows, clock, reset,
      req_take && req_chan.op == pil_pkg::OP_INSERT && !pos_bad && !list_full,
      count_ff == $past(count_ff) + pil_pkg::CNT_W'(1))

   // error and empty results always close their transaction
   `PIL_ASSERT_IMPL(a_err_is_last, clock, reset,
      rsp_valid_ff && rsp_status_ff != pil_pkg::ST_OK, rsp_last_ff)

endmodule

`default_nettype wire

// ----- rtl/pil_cell.sv -----
// ----------------------------------------------------------------------------
// pil_cell
// one list slot: holds, loads a new value, or takes a neighbor's or the wrap value
// ----------------------------------------------------------------------------
`default_nettype none

module pil_cell (
   input  wire logic                                clock,
   input  wire logic [pil_pkg::IDX_W-1:0]           idx,
   input  wire pil_pkg::cell_ctrl_type              ctrl,
   input  wire logic signed [pil_pkg::DATA_W-1:0]   left,
   input  wire logic signed [pil_pkg::DATA_W-1:0]   right,
   input  wire logic signed [pil_pkg::DATA_W-1:0]   wrap,
   output logic signed [pil_pkg::DATA_W-1:0]        data
);

   logic signed [pil_pkg::DATA_W-1:0] data_ff;
   logic signed [pil_pkg::DATA_W-1:0] data_in;
   logic [pil_pkg::CNT_W-1:0]         my_idx;
   logic [pil_pkg::CNT_W-1:0]         my_next;
   logic [pil_pkg::POS_W-1:0]         my_pos;

   assign my_idx  = pil_pkg::CNT_W'(idx);
   assign my_next = my_idx + pil_pkg::CNT_W'(1);
   assign my_pos  = pil_pkg::POS_W'(idx);

   always_comb begin
      data_in = data_ff;
      case (ctrl.mode)
         pil_pkg::MODE_INSERT: begin
            if (my_pos == ctrl.pos) begin
               data_in = ctrl.ins_value;
            end else if (my_pos > ctrl.pos && my_idx <= ctrl.count) begin
               data_in = left;
            end
         end
         pil_pkg::MODE_ROT_FWD: begin
            if (my_next < ctrl.count) begin
               data_in = right;
            end else if (my_next == ctrl.count) begin
               data_in = wrap;
            end
         end
         pil_pkg::MODE_ROT_BWD: begin
            if (my_idx == '0) begin
               data_in = wrap;
            end else if (my_idx < ctrl.count) begin
               data_in = left;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ----- rtl/pil_chain.sv -----
// ----------------------------------------------------------------------------
// pil_chain
// row of list cells with neighbor links and the rotate wrap path
// ----------------------------------------------------------------------------
`default_nettype none

module pil_chain (
   input  wire logic                                clock,
   input  wire pil_pkg::cell_ctrl_type              ctrl,
   output logic signed [pil_pkg::DATA_W-1:0]        head,
   output logic signed [pil_pkg::DATA_W-1:0]        tail
);

   logic signed [pil_pkg::DATA_W-1:0] cell_q [pil_pkg::CAPACITY];
   logic signed [pil_pkg::DATA_W-1:0] wrap;
   logic [pil_pkg::CNT_W-1:0]         tail_cnt;

   // tail select is only meaningful while the list is non-empty
   assign tail_cnt = ctrl.count - pil_pkg::CNT_W'(1);
   assign head     = cell_q[0];
   assign tail     = cell_q[tail_cnt[pil_pkg::IDX_W-1:0]];
   assign wrap     = (ctrl.mode == pil_pkg::MODE_ROT_BWD) ? tail : head;

   for (genvar i = 0; i < pil_pkg::CAPACITY; i++) begin : g_cell
      logic signed [pil_pkg::DATA_W-1:0] left_d;
      logic signed [pil_pkg::DATA_W-1:0] right_d;

      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_q[i-1];
      end

      if (i == pil_pkg::CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_q[i+1];
      end

      pil_cell u_cell (
         .clock (clock),
         .idx   (pil_pkg::IDX_W'(i)),
         .ctrl  (ctrl),
         .left  (left_d),
         .right (right_d),
         .wrap  (wrap),
         .data  (cell_q[i])
      );
   end

endmodule

`default_nettype wire
